// ===== rtl/core/hsv_to_rgb_converter_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold whenever the given valid bit is set.
`define HSV_ASSERT_VLD(lbl, vld, cond, msg) \
  `HSV_ASSERT(lbl, (vld) |-> (cond), msg)

`endif

// ===== rtl/core/hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point constants, sector codes and stage payload types.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam logic [14:0] HueFull    = 15'd23040;
  localparam logic [14:0] SectorSpan = 15'd3840;
  localparam logic [15:0] OneQ15     = 16'h8000;
  // Fraction is rem * 128 / 15, taken as (rem * 559241) >> 16.
  localparam logic [19:0] FracRecip  = 20'd559241;
  localparam int          NumSectors = 6;

  typedef enum logic [2:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4,
    SecMagentaRed  = 3'd5,
    SecWrap        = 3'd6
  } sector_e;

  typedef struct packed {
    sector_e     sector;
    logic [11:0] rem;
    logic [15:0] sat;
    logic [15:0] val;
  } split_t;

  typedef struct packed {
    sector_e     sector;
    logic [14:0] frac;
    logic [15:0] sat;
    logic [15:0] val;
  } frac_t;

  typedef struct packed {
    sector_e     sector;
    logic [15:0] val;
    logic [15:0] p;
    logic [15:0] one_m_sf;
    logic [15:0] one_m_st;
  } prod_t;

  typedef struct packed {
    sector_e     sector;
    logic [15:0] val;
    logic [15:0] p;
    logic [15:0] q;
    logic [15:0] t;
  } mix_t;

  typedef struct packed {
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
  } rgb_t;

  function automatic logic [7:0] level_to_byte(logic [15:0] level);
    logic [23:0] prod;
    prod = {level, 8'b0} - {8'b0, level};
    return prod[22:15];
  endfunction

endpackage

// ===== rtl/core/hsv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter channel interfaces
// Valid/ready channels for the HSV input words and the RGB output words.
// ----------------------------------------------------------------------------
interface hsv_pix_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

interface hsv_rgb_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_level;
  logic [15:0] green_level;
  logic [15:0] blue_level;
  logic [7:0]  red_byte;
  logic [7:0]  green_byte;
  logic [7:0]  blue_byte;

  modport source (output valid, output red_level, output green_level,
                  output blue_level, output red_byte, output green_byte,
                  output blue_byte, input ready);
  modport sink (input valid, input red_level, input green_level,
                input blue_level, input red_byte, input green_byte,
                input blue_byte, output ready);
endinterface

// ===== rtl/core/hsv_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV sector split
// Clamps the inputs, finds the hue sector and the Q1.15 fraction within it.
// ----------------------------------------------------------------------------
module hsv_sector import hsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [14:0] hue_i,
  input  logic [15:0] sat_i,
  input  logic [15:0] val_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output frac_t       out_data_o
);

  logic [14:0] hue_c;
  logic [14:0] base;
  split_t      split_d, split_q;
  logic        split_vld_q;
  logic        split_rdy;
  frac_t       frac_d, frac_q;
  logic        frac_vld_q;
  logic        frac_rdy;
  logic [31:0] frac_prod;

  assign hue_c = (hue_i > HueFull) ? HueFull : hue_i;

  always_comb begin
    split_d.sector = SecRedYellow;
    base           = '0;
    for (int k = 1; k <= NumSectors; k++) begin
      if (hue_c >= 15'(k) * SectorSpan) begin
        split_d.sector = sector_e'(3'(k));
        base           = 15'(k) * SectorSpan;
      end
    end
    split_d.rem = 12'(hue_c - base);
    split_d.sat = (sat_i > OneQ15) ? OneQ15 : sat_i;
    split_d.val = (val_i > OneQ15) ? OneQ15 : val_i;
  end

  assign frac_rdy   = !frac_vld_q || out_ready_i;
  assign split_rdy  = !split_vld_q || frac_rdy;
  assign in_ready_o = split_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_vld_q <= 1'b0;
      frac_vld_q  <= 1'b0;
    end else begin
      if (split_rdy) begin
        split_vld_q <= in_valid_i;
      end
      if (frac_rdy) begin
        frac_vld_q <= split_vld_q;
      end
    end
  end

  assign frac_prod = {20'b0, split_q.rem} * {12'b0, FracRecip};

  always_comb begin
    frac_d.sector = split_q.sector;
    frac_d.frac   = frac_prod[30:16];
    frac_d.sat    = split_q.sat;
    frac_d.val    = split_q.val;
  end

  always_ff @(posedge clk_i) begin
    if (split_rdy && in_valid_i) begin
      split_q <= split_d;
    end
    if (frac_rdy && split_vld_q) begin
      frac_q <= frac_d;
    end
  end

  assign out_valid_o = frac_vld_q;
  assign out_data_o  = frac_q;

endmodule

// ===== rtl/core/hsv_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV blend products
// Forms p, q and t from saturation, brightness and the sector fraction.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_blend import hsv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  frac_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output mix_t  out_data_o
);

  logic [30:0] sf_prod;
  logic [31:0] st_prod;
  logic [31:0] p_prod;
  logic [15:0] one_m_f;
  prod_t       prod_d, prod_q;
  logic        prod_vld_q;
  logic        prod_rdy;
  logic [31:0] q_prod;
  logic [31:0] t_prod;
  mix_t        mix_d, mix_q;
  logic        mix_vld_q;
  logic        mix_rdy;

  assign one_m_f = OneQ15 - {1'b0, in_data_i.frac};
  assign sf_prod = {15'b0, in_data_i.sat} * {16'b0, in_data_i.frac};
  assign st_prod = {16'b0, in_data_i.sat} * {16'b0, one_m_f};
  assign p_prod  = {16'b0, in_data_i.val} * {16'b0, OneQ15 - in_data_i.sat};

  always_comb begin
    prod_d.sector   = in_data_i.sector;
    prod_d.val      = in_data_i.val;
    prod_d.p        = p_prod[30:15];
    prod_d.one_m_sf = OneQ15 - sf_prod[30:15];
    prod_d.one_m_st = OneQ15 - st_prod[30:15];
  end

  assign q_prod = {16'b0, prod_q.val} * {16'b0, prod_q.one_m_sf};
  assign t_prod = {16'b0, prod_q.val} * {16'b0, prod_q.one_m_st};

  always_comb begin
    mix_d.sector = prod_q.sector;
    mix_d.val    = prod_q.val;
    mix_d.p      = prod_q.p;
    mix_d.q      = q_prod[30:15];
    mix_d.t      = t_prod[30:15];
  end

  assign mix_rdy    = !mix_vld_q || out_ready_i;
  assign prod_rdy   = !prod_vld_q || mix_rdy;
  assign in_ready_o = prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      mix_vld_q  <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_vld_q <= in_valid_i;
      end
      if (mix_rdy) begin
        mix_vld_q <= prod_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (mix_rdy && prod_vld_q) begin
      mix_q <= mix_d;
    end
  end

  assign out_valid_o = mix_vld_q;
  assign out_data_o  = mix_q;

  `HSV_ASSERT_VLD(p_le_val_a, mix_vld_q, mix_q.p <= mix_q.val, "p exceeds brightness")
  `HSV_ASSERT_VLD(q_le_val_a, mix_vld_q, mix_q.q <= mix_q.val, "q exceeds brightness")
  `HSV_ASSERT_VLD(t_le_val_a, mix_vld_q, mix_q.t <= mix_q.val, "t exceeds brightness")
  `HSV_ASSERT(mix_hold_a, (mix_vld_q && !out_ready_i) |=> $stable(mix_q), "mix word changed while stalled")

endmodule

// ===== rtl/core/hsv_route.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV channel routing
// Routes v, p, q and t to the colour channels by sector and forms the bytes.
// ----------------------------------------------------------------------------
module hsv_route import hsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mix_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rgb_t out_data_o
);

  logic [15:0] red, green, blue;
  rgb_t        rgb_d, rgb_q;
  logic        rgb_vld_q;
  logic        rgb_rdy;

  always_comb begin
    case (in_data_i.sector)
      SecYellowGreen: begin
        red = in_data_i.q;   green = in_data_i.val; blue = in_data_i.p;
      end
      SecGreenCyan: begin
        red = in_data_i.p;   green = in_data_i.val; blue = in_data_i.t;
      end
      SecCyanBlue: begin
        red = in_data_i.p;   green = in_data_i.q;   blue = in_data_i.val;
      end
      SecBlueMagenta: begin
        red = in_data_i.t;   green = in_data_i.p;   blue = in_data_i.val;
      end
      SecMagentaRed: begin
        red = in_data_i.val; green = in_data_i.p;   blue = in_data_i.q;
      end
      default: begin
        red = in_data_i.val; green = in_data_i.t;   blue = in_data_i.p;
      end
    endcase
  end

  always_comb begin
    rgb_d.red_level   = red;
    rgb_d.green_level = green;
    rgb_d.blue_level  = blue;
    rgb_d.red_byte    = level_to_byte(red);
    rgb_d.green_byte  = level_to_byte(green);
    rgb_d.blue_byte   = level_to_byte(blue);
  end

  assign rgb_rdy    = !rgb_vld_q || out_ready_i;
  assign in_ready_o = rgb_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_vld_q <= 1'b0;
    end else if (rgb_rdy) begin
      rgb_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rgb_rdy && in_valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = rgb_vld_q;
  assign out_data_o  = rgb_q;

endmodule

// ===== rtl/core/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline turning HSV words with Q1.15 saturation and brightness into Q1.15 and byte RGB words.
// ----------------------------------------------------------------------------
// The converter accepts one HSV word per clock while the output is not
// stalled, and returns one RGB word for each, in order. The five register
// stages are: input clamp and sector split, the fraction multiply, the
// saturation products, the brightness products, and channel routing with
// byte conversion. Each stage holds its word while the next is full, so
// back-pressure on the output stalls the pipeline without losing or
// repeating words, and empty stages still fill while it waits.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsv_pix_if.sink    pix_i,
  hsv_rgb_if.source  rgb_o
);

  logic  frac_vld;
  logic  frac_rdy;
  frac_t frac_data;
  logic  mix_vld;
  logic  mix_rdy;
  mix_t  mix_data;
  rgb_t  rgb_data;

  hsv_sector u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .hue_i       (pix_i.hue),
    .sat_i       (pix_i.saturation),
    .val_i       (pix_i.brightness),
    .out_valid_o (frac_vld),
    .out_ready_i (frac_rdy),
    .out_data_o  (frac_data)
  );

  hsv_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frac_vld),
    .in_ready_o  (frac_rdy),
    .in_data_i   (frac_data),
    .out_valid_o (mix_vld),
    .out_ready_i (mix_rdy),
    .out_data_o  (mix_data)
  );

  hsv_route u_route (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_vld),
    .in_ready_o  (mix_rdy),
    .in_data_i   (mix_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (rgb_data)
  );

  assign rgb_o.red_level   = rgb_data.red_level;
  assign rgb_o.green_level = rgb_data.green_level;
  assign rgb_o.blue_level  = rgb_data.blue_level;
  assign rgb_o.red_byte    = rgb_data.red_byte;
  assign rgb_o.green_byte  = rgb_data.green_byte;
  assign rgb_o.blue_byte   = rgb_data.blue_byte;

endmodule
